[rtl/hte_pkg.sv]
// Shared types, constants and character functions for the text escaper.
package hte_pkg;

    // Escape modes held in the configuration register
    localparam logic MODE_HREF = 1'b0;
    localparam logic MODE_HTML = 1'b1;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Longest expansion of one byte, and width of the position counter
    localparam int MAX_RUN = 6;
    localparam int IDX_W   = $clog2(MAX_RUN);

    // How one input byte expands
    typedef enum logic [2:0] {
        ESC_PASS,       // byte itself
        ESC_PCT,        // %XX
        ESC_AMP,        // &amp;
        ESC_APOS_HEX,   // &#x27;
        ESC_QUOT,       // &quot;
        ESC_APOS_DEC,   // &#39;
        ESC_LT,         // &lt;
        ESC_GT          // &gt;
    } esc_kind_t;

    typedef struct packed {
        esc_kind_t   kind;
        logic [7:0]  data;
        logic        last;
    } esc_item_t;

    typedef struct packed {
        logic        valid;
        esc_item_t   item;
    } q_head_t;

    // Upper-case hex digit for one nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10)
            ch = 8'h30 + {4'd0, nib};
        else
            ch = 8'h37 + {4'd0, nib};
        return ch;
    endfunction

    // Number of output bytes for a kind
    function automatic logic [IDX_W-1:0] esc_len(input esc_kind_t kind);
        logic [IDX_W-1:0] n;
        case (kind)
            ESC_PASS:     n = IDX_W'(1);
            ESC_PCT:      n = IDX_W'(3);
            ESC_AMP:      n = IDX_W'(5);
            ESC_APOS_HEX: n = IDX_W'(6);
            ESC_QUOT:     n = IDX_W'(6);
            ESC_APOS_DEC: n = IDX_W'(5);
            ESC_LT:       n = IDX_W'(4);
            ESC_GT:       n = IDX_W'(4);
            default:      n = IDX_W'(1);
        endcase
        return n;
    endfunction

    // Output byte at position idx of the expansion
    function automatic logic [7:0] esc_char(input esc_kind_t kind,
                                            input logic [7:0] c,
                                            input logic [IDX_W-1:0] idx);
        logic [7:0] ch;
        ch = c;
        case (kind)
            ESC_PASS: ch = c;
            ESC_PCT:
                case (idx)
                    IDX_W'(0): ch = "%";
                    IDX_W'(1): ch = hex_digit(c[7:4]);
                    default:   ch = hex_digit(c[3:0]);
                endcase
            ESC_AMP:
                case (idx)
                    IDX_W'(0): ch = "&";
                    IDX_W'(1): ch = "a";
                    IDX_W'(2): ch = "m";
                    IDX_W'(3): ch = "p";
                    default:   ch = ";";
                endcase
            ESC_APOS_HEX:
                case (idx)
                    IDX_W'(0): ch = "&";
                    IDX_W'(1): ch = "#";
                    IDX_W'(2): ch = "x";
                    IDX_W'(3): ch = "2";
                    IDX_W'(4): ch = "7";
                    default:   ch = ";";
                endcase
            ESC_QUOT:
                case (idx)
                    IDX_W'(0): ch = "&";
                    IDX_W'(1): ch = "q";
                    IDX_W'(2): ch = "u";
                    IDX_W'(3): ch = "o";
                    IDX_W'(4): ch = "t";
                    default:   ch = ";";
                endcase
            ESC_APOS_DEC:
                case (idx)
                    IDX_W'(0): ch = "&";
                    IDX_W'(1): ch = "#";
                    IDX_W'(2): ch = "3";
                    IDX_W'(3): ch = "9";
                    default:   ch = ";";
                endcase
            ESC_LT:
                case (idx)
                    IDX_W'(0): ch = "&";
                    IDX_W'(1): ch = "l";
                    IDX_W'(2): ch = "t";
                    default:   ch = ";";
                endcase
            ESC_GT:
                case (idx)
                    IDX_W'(0): ch = "&";
                    IDX_W'(1): ch = "g";
                    IDX_W'(2): ch = "t";
                    default:   ch = ";";
                endcase
            default: ch = c;
        endcase
        return ch;
    endfunction

endpackage

[rtl/hte_front.sv]
// Front end: input register, mode register and byte classification.
module hte_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         text_byte,
    input  logic               text_last,
    input  logic               q_full,
    output logic               push,
    output hte_pkg::esc_item_t push_item
);

    logic               mode_reg;
    logic               stage_valid_reg;
    logic               stage_valid_next;
    logic [7:0]         stage_byte_reg;
    logic               stage_last_reg;
    hte_pkg::esc_kind_t kind;
    logic               accept;

    assign in_stall = stage_valid_reg & q_full;
    assign accept   = in_valid & ~in_stall;
    assign push     = stage_valid_reg & ~q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= hte_pkg::MODE_HREF;
        end
        else if (cfg_wr_en)
        begin
            mode_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
            stage_valid_next = 1'b1;
        else if (push)
            stage_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_byte_reg <= text_byte;
            stage_last_reg <= text_last;
        end
    end

    // Classify the held byte under the current mode
    always_comb
    begin
        kind = hte_pkg::ESC_PASS;
        if (mode_reg == hte_pkg::MODE_HREF)
        begin
            if (stage_byte_reg inside {8'h21, [8'h23:8'h25], [8'h28:8'h3B], 8'h3D,
                                       [8'h3F:8'h5A], 8'h5F, [8'h61:8'h7A]})
                kind = hte_pkg::ESC_PASS;
            else if (stage_byte_reg == "&")
                kind = hte_pkg::ESC_AMP;
            else if (stage_byte_reg == "'")
                kind = hte_pkg::ESC_APOS_HEX;
            else
                kind = hte_pkg::ESC_PCT;
        end
        else
        begin
            case (stage_byte_reg)
                "\"":    kind = hte_pkg::ESC_QUOT;
                "&":     kind = hte_pkg::ESC_AMP;
                "'":     kind = hte_pkg::ESC_APOS_DEC;
                "<":     kind = hte_pkg::ESC_LT;
                ">":     kind = hte_pkg::ESC_GT;
                default: kind = hte_pkg::ESC_PASS;
            endcase
        end
    end

    assign push_item.kind = kind;
    assign push_item.data = stage_byte_reg;
    assign push_item.last = stage_last_reg;

endmodule

[rtl/hte_queue.sv]
// Short queue of classified bytes between front and back.
module hte_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hte_pkg::esc_item_t push_item,
    output logic               full,
    input  logic               pop,
    output hte_pkg::q_head_t   head
);

    hte_pkg::esc_item_t             slot_reg [hte_pkg::QDEPTH];
    logic [hte_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [hte_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [hte_pkg::QCNT_W-1:0]     cnt_reg;
    logic [hte_pkg::QCNT_W-1:0]     cnt_next;
    logic                           do_pop;

    assign full       = (cnt_reg == hte_pkg::QCNT_W'(hte_pkg::QDEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.item  = slot_reg[rd_ptr_reg];
    assign do_pop     = pop & head.valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!push && do_pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

[rtl/hte_back.sv]
// Back end: expand the head entry into output bytes, one per cycle unless out_stall holds the output.
module hte_back (
    input  logic             clk,
    input  logic             rst_n,
    input  hte_pkg::q_head_t head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic             run_last,
    output logic             text_end
);

    logic                      out_valid_reg;
    logic [7:0]                out_byte_reg;
    logic                      run_last_reg;
    logic                      text_end_reg;
    logic [hte_pkg::IDX_W-1:0] idx_reg;
    logic [hte_pkg::IDX_W-1:0] idx_next;
    logic                      advance;
    logic                      fin;

    assign advance = ~out_valid_reg | ~out_stall;
    assign fin     = (idx_reg == hte_pkg::esc_len(head.item.kind) - 1'b1);
    assign pop     = advance & head.valid & fin;

    always_comb
    begin
        idx_next = idx_reg;
        if (advance && head.valid)
            idx_next = fin ? '0 : idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (advance)
                out_valid_reg <= head.valid;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && head.valid)
        begin
            out_byte_reg <= hte_pkg::esc_char(head.item.kind, head.item.data, idx_reg);
            run_last_reg <= fin;
            text_end_reg <= fin & head.item.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;
    assign text_end  = text_end_reg;

endmodule

[rtl/href_and_html_text_escaper.sv]
// Top level of the href / html text escaper.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------
//  cfg     | in        | cfg_wr_en           | cfg_wr_data (escape mode)
//  in      | in        | in_valid / in_stall | text_byte, text_last
//  out     | out       | out_valid/out_stall | out_byte, run_last, text_end
//
// One input transaction yields 1 to 6 output transactions, one per cycle while out_stall is low;
// the output register sets the pace, so bytes that pass unchanged flow at
// one per cycle and an escaped byte holds the back end for its length.
// The first output byte is registered through the input stage, a queue
// slot and the output register after the input transaction is accepted.
// Reset clears the mode to href and empties the input stage, queue and
// output register; no clearing pass is needed.
// A stall on the output holds the current byte and, once the two-entry
// queue fills, raises in_stall; the front keeps taking bytes until then.
// Write the mode register only while no text is in flight.
module href_and_html_text_escaper (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_byte,
    input  logic       text_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       text_end
);

    logic               push;
    logic               q_full;
    logic               pop;
    hte_pkg::esc_item_t push_item;
    hte_pkg::q_head_t   head;

    // Accept and classify
    hte_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .text_byte   (text_byte),
        .text_last   (text_last),
        .q_full      (q_full),
        .push        (push),
        .push_item   (push_item)
    );

    // Decouple the two halves
    hte_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .head      (head)
    );

    // Expand into output transactions
    hte_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .text_end  (text_end)
    );

endmodule

[rtl/hte_checker.sv]
// Port-level checks for the text escaper, bound to the top level.
module hte_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       text_end
);

    // Hold a stalled output transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(run_last) && $stable(text_end))
        else $error("stalled output changed");

    // End of text only on the last byte of a run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!text_end || run_last))
        else $error("text_end without run_last");

    // A run, once started, continues without a gap
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !run_last |=> out_valid)
        else $error("gap inside an expansion run");

    // No output on the first edge after reset
    assert property (@(posedge clk)
        rst_n && !$past(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

endmodule

bind href_and_html_text_escaper hte_checker u_hte_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .text_end  (text_end)
);
